### src/vac_pkg.sv
// ----------------------------------------------------------------------------
// vac_pkg: shared types and defaults for the vector angle cosine core.
// Holds the control word that travels with each item and parameter defaults.
// ----------------------------------------------------------------------------
package vac_pkg;

    // Default component width and number of fraction bits of the result.
    localparam int DEF_COMP_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 14;

    // Control word carried down the pipeline beside each item.
    typedef struct packed {
        logic valid;
        logic neg;
        logic degen;
    } t_ctl;

endpackage

### src/vector_angle_cosine_core.sv
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// The receiver cannot stall; each result shows for one cycle with o_valid.
// Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
// vector_angle_cosine_core: cosine of the angle between two 3D vectors.
// Products, sums, a wide product and a wide square, then one search stage per result bit.
// ----------------------------------------------------------------------------
module vector_angle_cosine_core #(
    parameter int COMP_WIDTH = vac_pkg::DEF_COMP_WIDTH,
    parameter int FRAC_BITS  = vac_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COMP_WIDTH-1:0] i_a_x,
    input  logic signed [COMP_WIDTH-1:0] i_a_y,
    input  logic signed [COMP_WIDTH-1:0] i_a_z,
    input  logic signed [COMP_WIDTH-1:0] i_b_x,
    input  logic signed [COMP_WIDTH-1:0] i_b_y,
    input  logic signed [COMP_WIDTH-1:0] i_b_z,
    output logic                         o_valid,
    output logic signed [FRAC_BITS+1:0]  o_cosine,
    output logic                         o_degenerate
);
    import vac_pkg::*;

    localparam int P  = 2 * COMP_WIDTH;
    localparam int D  = P + 2;
    localparam int M  = 2 * P;
    localparam int W  = 2 * M + 2 * FRAC_BITS + 4 - M;
    localparam int OW = FRAC_BITS + 2;
    localparam int NS = FRAC_BITS + 1;

    // Stage 1: component products.
    logic                r_v1;
    logic signed [P-1:0] r_xx, r_yy, r_zz;
    logic signed [P-1:0] r_ax2, r_ay2, r_az2;
    logic signed [P-1:0] r_bx2, r_by2, r_bz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx  <= P'(i_a_x) * P'(i_b_x);
        r_yy  <= P'(i_a_y) * P'(i_b_y);
        r_zz  <= P'(i_a_z) * P'(i_b_z);
        r_ax2 <= P'(i_a_x) * P'(i_a_x);
        r_ay2 <= P'(i_a_y) * P'(i_a_y);
        r_az2 <= P'(i_a_z) * P'(i_a_z);
        r_bx2 <= P'(i_b_x) * P'(i_b_x);
        r_by2 <= P'(i_b_y) * P'(i_b_y);
        r_bz2 <= P'(i_b_z) * P'(i_b_z);
    end

    // Stage 2: dot product magnitude and sign, squared lengths.
    logic signed [D-1:0] w_dot;
    logic signed [D-1:0] w_la;
    logic signed [D-1:0] w_lb;
    logic signed [D-1:0] w_abs;
    t_ctl                r_ctl2;
    logic [P-1:0]        r_mag;
    logic [P-1:0]        r_la;
    logic [P-1:0]        r_lb;

    assign w_dot = D'(r_xx) + D'(r_yy) + D'(r_zz);
    assign w_la  = D'(r_ax2) + D'(r_ay2) + D'(r_az2);
    assign w_lb  = D'(r_bx2) + D'(r_by2) + D'(r_bz2);
    assign w_abs = w_dot[D-1] ? -w_dot : w_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2.valid <= r_v1;
            r_ctl2.neg   <= w_dot[D-1];
            r_ctl2.degen <= (w_la == '0) || (w_lb == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= w_abs[P-1:0];
        r_la  <= w_la[P-1:0];
        r_lb  <= w_lb[P-1:0];
    end

    // Stages 3 and 4: p = la * lb and the squared dot magnitude.
    logic [M-1:0] w_p;
    logic [M-1:0] w_mag2;
    t_ctl         r_ctl3;
    t_ctl         r_ctl4;

    vac_mul #(.N(P)) u_mul_p (
        .i_clk (i_clk),
        .i_a   (r_la),
        .i_b   (r_lb),
        .o_p   (w_p)
    );

    vac_mul #(.N(P)) u_mul_d (
        .i_clk (i_clk),
        .i_a   (r_mag),
        .i_b   (r_mag),
        .o_p   (w_mag2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    // Search chain: start from r = 0, so (2r-1)^2 * p = p and (2r-1) * p = -p.
    t_ctl                c_ctl [NS+1];
    logic signed [W-1:0] c_s   [NS+1];
    logic signed [W-1:0] c_t   [NS+1];
    logic signed [W-1:0] c_p   [NS+1];
    logic signed [W-1:0] c_rhs [NS+1];
    logic [FRAC_BITS:0]  c_r   [NS+1];

    assign c_ctl[0] = r_ctl4;
    assign c_p[0]   = $signed({{(W-M){1'b0}}, w_p});
    assign c_s[0]   = c_p[0];
    assign c_t[0]   = -c_p[0];
    assign c_rhs[0] = $signed({{(W-M){1'b0}}, w_mag2}) <<< (2 * FRAC_BITS + 2);
    assign c_r[0]   = '0;

    for (genvar i = 0; i < NS; i++) begin : g_srch
        vac_srch_stage #(
            .W         (W),
            .FRAC_BITS (FRAC_BITS),
            .K         (FRAC_BITS - i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[i]),
            .i_s     (c_s[i]),
            .i_t     (c_t[i]),
            .i_p     (c_p[i]),
            .i_rhs   (c_rhs[i]),
            .i_r     (c_r[i]),
            .o_ctl   (c_ctl[i+1]),
            .o_s     (c_s[i+1]),
            .o_t     (c_t[i+1]),
            .o_p     (c_p[i+1]),
            .o_rhs   (c_rhs[i+1]),
            .o_r     (c_r[i+1])
        );
    end

    // Output stage: apply the sign, or force zero for a zero-length vector.
    logic signed [OW-1:0] w_rmag;
    logic                 r_valid;
    logic signed [OW-1:0] r_cos;
    logic                 r_degen;

    assign w_rmag = $signed({1'b0, c_r[NS]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= c_ctl[NS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_degen <= c_ctl[NS].degen;
        if (c_ctl[NS].degen) begin
            r_cos <= '0;
        end else if (c_ctl[NS].neg) begin
            r_cos <= -w_rmag;
        end else begin
            r_cos <= w_rmag;
        end
    end

    assign busy         = 1'b0;
    assign o_valid      = r_valid;
    assign o_cosine     = r_cos;
    assign o_degenerate = r_degen;
endmodule

### src/vac_mul.sv
// ----------------------------------------------------------------------------
// vac_mul: two-stage unsigned multiplier.
// The operands are split in halves; partial products are registered first
// and summed in the second stage.
// ----------------------------------------------------------------------------
module vac_mul #(
    parameter int N = 32
) (
    input  logic           i_clk,
    input  logic [N-1:0]   i_a,
    input  logic [N-1:0]   i_b,
    output logic [2*N-1:0] o_p
);
    localparam int L = N / 2;
    localparam int H = N - L;

    logic [2*L-1:0] r_ll;
    logic [L+H-1:0] r_lh;
    logic [L+H-1:0] r_hl;
    logic [2*H-1:0] r_hh;
    logic [2*N-1:0] r_p;

    // First stage: four partial products.
    always_ff @(posedge i_clk) begin
        r_ll <= i_a[L-1:0] * i_b[L-1:0];
        r_lh <= (L+H)'(i_a[L-1:0]) * (L+H)'(i_b[N-1:L]);
        r_hl <= (L+H)'(i_a[N-1:L]) * (L+H)'(i_b[L-1:0]);
        r_hh <= i_a[N-1:L] * i_b[N-1:L];
    end

    // Second stage: weighted sum of the partial products.
    always_ff @(posedge i_clk) begin
        r_p <= (2*N)'(r_ll)
             + ((2*N)'(r_lh) << L)
             + ((2*N)'(r_hl) << L)
             + ((2*N)'(r_hh) << (2*L));
    end

    assign o_p = r_p;
endmodule

### src/vac_srch_stage.sv
// ----------------------------------------------------------------------------
// vac_srch_stage: one bit of the result magnitude search.
// Tries to set bit K of r, keeping (2r-1)^2 * p and (2r-1) * p up to date
// with shifts and adds, and keeps the bit if the square stays within rhs.
// ----------------------------------------------------------------------------
module vac_srch_stage #(
    parameter int W         = 96,
    parameter int FRAC_BITS = 14,
    parameter int K         = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vac_pkg::t_ctl         i_ctl,
    input  logic signed [W-1:0]   i_s,
    input  logic signed [W-1:0]   i_t,
    input  logic signed [W-1:0]   i_p,
    input  logic signed [W-1:0]   i_rhs,
    input  logic [FRAC_BITS:0]    i_r,
    output vac_pkg::t_ctl         o_ctl,
    output logic signed [W-1:0]   o_s,
    output logic signed [W-1:0]   o_t,
    output logic signed [W-1:0]   o_p,
    output logic signed [W-1:0]   o_rhs,
    output logic [FRAC_BITS:0]    o_r
);
    import vac_pkg::*;

    localparam int RW = FRAC_BITS + 1;

    logic signed [W-1:0] w_cand;
    logic                w_allow;
    logic                w_take;

    t_ctl                r_ctl;
    logic signed [W-1:0] r_s;
    logic signed [W-1:0] r_t;
    logic signed [W-1:0] r_p;
    logic signed [W-1:0] r_rhs;
    logic [RW-1:0]       r_r;

    // Candidate square for r with bit K set; r may not pass 2^FRAC_BITS.
    assign w_cand  = i_s + (i_t <<< (K + 2)) + (i_p <<< (2 * K + 2));
    assign w_allow = (K == FRAC_BITS) || !i_r[FRAC_BITS];
    assign w_take  = w_allow && (w_cand <= i_rhs);

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_p   <= i_p;
        r_rhs <= i_rhs;
        if (w_take) begin
            r_s <= w_cand;
            r_t <= i_t + (i_p <<< (K + 1));
            r_r <= i_r | (RW'(1) << K);
        end else begin
            r_s <= i_s;
            r_t <= i_t;
            r_r <= i_r;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_t   = r_t;
    assign o_p   = r_p;
    assign o_rhs = r_rhs;
    assign o_r   = r_r;
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vector angle cosine core.
// Drives vector pairs with random idle bursts and predicts each cosine with
// an exact integer search, comparing every result in order of issue.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW        = vac_pkg::DEF_COMP_WIDTH;
    localparam int FB        = vac_pkg::DEF_FRAC_BITS;
    localparam int LATENCY   = FB + 6;
    localparam int N_RANDOM  = 700;
    localparam int CYCLE_MAX = 200000;

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [FB+1:0] t_cos;

    // One stimulus row; has_exp marks rows whose result is typed in.
    typedef struct {
        t_comp ax, ay, az, bx, by, bz;
        bit    has_exp;
        t_cos  exp_cos;
        bit    exp_degen;
    } t_row;

    typedef struct {
        t_cos cosine;
        bit   degen;
    } t_cos_result;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_comp i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z;
    logic  o_valid;
    t_cos  o_cosine;
    logic  o_degenerate;

    t_cos_result pending_cos[$];
    int          n_errors = 0;
    int          cycle_cnt = 0;

    vector_angle_cosine_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .o_valid(o_valid), .o_cosine(o_cosine), .o_degenerate(o_degenerate)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Exact cosine: largest r in [0, 2^FB] with (2r-1)^2 * la * lb <= 4 dot^2 2^(2FB).
    function automatic t_cos_result predict_cosine(t_comp ax, t_comp ay, t_comp az,
                                                   t_comp bx, t_comp by, t_comp bz);
        t_cos_result res;
        longint      dot;
        longint      la;
        longint      lb;
        bit [255:0]  prod;
        bit [255:0]  rhs;
        bit [255:0]  lhs;
        longint      mag;
        longint      lo;
        longint      hi;
        longint      mid;
        longint      d;
        dot = longint'(ax) * bx + longint'(ay) * by + longint'(az) * bz;
        la  = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        lb  = longint'(bx) * bx + longint'(by) * by + longint'(bz) * bz;
        res.cosine = '0;
        res.degen  = 1'b0;
        if (la == 0 || lb == 0) begin
            res.degen = 1'b1;
            return res;
        end
        mag  = (dot < 0) ? -dot : dot;
        prod = 256'(la) * 256'(lb);
        rhs  = (256'(mag) * 256'(mag)) << (2 * FB + 2);
        lo = 0;
        hi = longint'(1) << FB;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            d   = 2 * mid - 1;
            lhs = 256'(d * d) * prod;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        res.cosine = (dot < 0) ? t_cos'(-lo) : t_cos'(lo);
        return res;
    endfunction

    // Mismatch reporting.
    task automatic report_mismatch(string what);
        n_errors++;
        $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
    endtask

    // Result checking against the oldest expected cosine.
    always @(posedge i_clk) begin
        t_cos_result e;
        if (i_rst_n && o_valid) begin
            if (pending_cos.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                e = pending_cos.pop_front();
                if (o_cosine !== e.cosine)
                    report_mismatch($sformatf("cosine %0d, expected %0d",
                                              o_cosine, e.cosine));
                if (o_degenerate !== e.degen)
                    report_mismatch($sformatf("degenerate %0b, expected %0b",
                                              o_degenerate, e.degen));
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random component, biased toward extremes, zero and small values.
    function automatic t_comp rand_comp();
        case ($urandom_range(0, 7))
            0: return t_comp'(-(1 << (CW - 1)));
            1: return t_comp'((1 << (CW - 1)) - 1);
            2: return '0;
            3: return t_comp'($signed($urandom_range(0, 6)) - 3);
            default: return t_comp'($urandom);
        endcase
    endfunction

    // Presents one item, waits for acceptance, queues its expected result.
    task automatic send_item(t_row r);
        t_cos_result e;
        i_a_x <= r.ax; i_a_y <= r.ay; i_a_z <= r.az;
        i_b_x <= r.bx; i_b_y <= r.by; i_b_z <= r.bz;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        e = predict_cosine(r.ax, r.ay, r.az, r.bx, r.by, r.bz);
        if (r.has_exp && (e.cosine !== r.exp_cos || e.degen !== r.exp_degen))
            report_mismatch("typed expectation disagrees with prediction");
        if (r.has_exp) begin
            e.cosine = r.exp_cos;
            e.degen  = r.exp_degen;
        end
        pending_cos.push_back(e);
    endtask

    t_row directed[$];
    localparam t_comp MX = t_comp'((1 << (CW - 1)) - 1);
    localparam t_comp MN = t_comp'(-(1 << (CW - 1)));
    localparam t_cos  ONE = t_cos'(1 << FB);

    function automatic t_row mk(t_comp ax, t_comp ay, t_comp az, t_comp bx, t_comp by,
                                t_comp bz, bit he, t_cos ec, bit ed);
        t_row r;
        r = '{ax, ay, az, bx, by, bz, he, ec, ed};
        return r;
    endfunction

    // Stimulus sequence.
    initial begin
        t_row r;
        int   idle;
        i_rst_n = 1'b0;
        start = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z} = '0;

        // Directed rows: zero vectors, parallel, antiparallel, orthogonal, extremes.
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 1));
        directed.push_back(mk(0, 0, 0, 5, 1, 2, 1, 0, 1));
        directed.push_back(mk(3, 4, 5, 0, 0, 0, 1, 0, 1));
        directed.push_back(mk(1, 0, 0, 1, 0, 0, 1, ONE, 0));
        directed.push_back(mk(1, 0, 0, -1, 0, 0, 1, -ONE, 0));
        directed.push_back(mk(1, 0, 0, 0, 1, 0, 1, 0, 0));
        directed.push_back(mk(MX, MX, MX, MX, MX, MX, 1, ONE, 0));
        directed.push_back(mk(MN, MN, MN, MN, MN, MN, 1, ONE, 0));
        directed.push_back(mk(MN, MN, MN, MX, MX, MX, 0, 0, 0));
        directed.push_back(mk(MN, 0, 0, MN, 0, 0, 1, ONE, 0));
        directed.push_back(mk(MN, 0, 0, MX, 0, 0, 1, -ONE, 0));
        directed.push_back(mk(0, 0, MX, 0, 0, -1, 1, -ONE, 0));
        directed.push_back(mk(1, 1, 0, 1, 0, 0, 0, 0, 0));
        directed.push_back(mk(1, 2, 3, -4, 5, -6, 0, 0, 0));
        directed.push_back(mk(MX, 1, 0, 1, MX, 0, 0, 0, 0));
        directed.push_back(mk(-1, -1, -1, 1, 1, 1, 1, -ONE, 0));
        directed.push_back(mk(1, 2, 0, 2, 1, 0, 0, 0, 0));
        directed.push_back(mk(-21846, 21845, -1, 21845, -21846, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_item(directed[k]);

        for (int n = 0; n < N_RANDOM; n++) begin
            r = mk(rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), 0, 0, 0);
            // Sometimes make B a copy or the negation of A to hit the clamp region.
            if ($urandom_range(0, 9) == 0) begin
                r.bx = -r.ax; r.by = -r.ay; r.bz = -r.az;
            end else if ($urandom_range(0, 9) == 0) begin
                r.bx = r.ax; r.by = r.ay; r.bz = r.az;
            end
            // Idle bursts on the sender side, none in the last part.
            if (n < N_RANDOM - 100 && $urandom_range(0, 3) == 0) begin
                idle = $urandom_range(1, 13);
                start <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            send_item(r);
        end
        start <= 1'b0;

        // Drain, then allow for the pipeline latency.
        while (pending_cos.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
